@@ design/dfrr_pkg.sv @@
// Package for the delimited frame receive ring.
// Holds the command codes, the queue entry and status types and fixed constants.
// No dependencies.
`default_nettype none

package dfrr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  // Widest slot index the ring supports (up to sixteen slots).
  localparam int unsigned SLOT_MAX_W = 4;

  localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'd10;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_ERR   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic                  reading;
    logic [SLOT_MAX_W-1:0] wr_slot;
    logic [SLOT_MAX_W-1:0] rd_slot;
  } back_status_t;

endpackage

`default_nettype wire

@@ design/delimited_frame_receive_ring.sv @@
// Delimited frame receive ring, top level. Depends on dfrr_pkg, dfrr_front,
// dfrr_fifo and dfrr_back.
// Throughput: one received byte per cycle while the queue has room; a read drains
// one frame byte per cycle while out_stall_i is low. Frame bytes pass the memory
// output and output registers; an empty answer skips the memory read.
// Reset (rst_ni low, asynchronous) empties the ring and queue and sets end_marker to 10.
`default_nettype none

// The block is split into a front end, a four-entry command queue and a back end.
//
// The front end holds the end_marker register and turns each accepted input beat
// into one command: a data byte, a reception error, a frame close or a read
// request. It stalls only when the queue is full.
//
// The back end executes one command per cycle while it is not reading out a frame
// and, for a read, while the output path has room: data bytes go into the frame store at
// the current write slot, the end marker writes the zero terminator and records the
// slot's last index, and an error restarts the frame. A read of a waiting frame issues
// each stored byte (terminator included) in turn from the frame store, and commands behind it
// wait in the queue until the frame has been issued. The read data passes a memory
// output register and then the output register, so one beat per cycle flows out
// while the consumer keeps stall low, and the path holds when it raises stall.
//
// A frame that closes when the ring already holds SLOTS-1 frames is discarded and
// flagged; the flag rides on every beat of the next read and is then cleared.
// Data bytes past FRAME_BYTES-1 in one frame are dropped.

module delimited_frame_receive_ring
  import dfrr_pkg::*;
#(
  parameter int unsigned SLOTS       = 6,
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [BYTE_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic              comm_error_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      frame_byte_o,
  output logic                   byte_valid_o,
  output logic                   last_o,
  output logic                   overflow_seen_o
);

  logic         q_full, q_push, q_pop, q_valid;
  cmd_t         q_in, q_out;
  back_status_t status;

  dfrr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .rx_byte_i   (rx_byte_i),
    .comm_error_i(comm_error_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in)
  );

  dfrr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_out),
    .valid_o(q_valid)
  );

  dfrr_back #(
    .SLOTS      (SLOTS),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_out),
    .cmd_valid_i    (q_valid),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .overflow_seen_o(overflow_seen_o),
    .status_o       (status)
  );

  // Both slot pointers stay inside the ring.
  a_slots_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(status.wr_slot) < SLOTS) && (32'(status.rd_slot) < SLOTS))
    else $error("slot pointer outside the ring");

  // A frame is only read out while the ring holds at least one frame.
  a_read_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.reading |-> (status.wr_slot != status.rd_slot))
    else $error("frame readout from an empty ring");

  // The empty-ring answer is a single terminating beat with a zero byte.
  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (last_o && (frame_byte_o == '0)))
    else $error("malformed empty-ring answer");

  // Every frame ends on its zero terminator.
  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (frame_byte_o == '0))
    else $error("frame does not end on its terminator");

endmodule

`default_nettype wire

@@ design/dfrr_front.sv @@
// Front end of the frame ring: holds the end marker register, accepts input
// beats and classifies each one into a command. Uses dfrr_pkg.
`default_nettype none

module dfrr_front
  import dfrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [BYTE_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic              comm_error_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output cmd_t                   q_cmd_o
);

  logic [BYTE_W-1:0] end_marker_q, end_marker_d;

  assign end_marker_d = cfg_we_i ? cfg_wdata_i : end_marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= END_MARKER_RST;
    end else begin
      end_marker_q <= end_marker_d;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.data = rx_byte_i;
    if (action_i) begin
      q_cmd_o.kind = CMD_READ;
    end else if (comm_error_i) begin
      q_cmd_o.kind = CMD_ERR;
    end else if (rx_byte_i == end_marker_q) begin
      q_cmd_o.kind = CMD_CLOSE;
    end else begin
      q_cmd_o.kind = CMD_DATA;
    end
  end

endmodule

`default_nettype wire

@@ design/dfrr_fifo.sv @@
// Short command queue between the front end and the back end of the ring.
// Uses dfrr_pkg for the entry type and depth.
`default_nettype none

module dfrr_fifo
  import dfrr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      valid_o
);

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ design/dfrr_back.sv @@
// Back end of the frame ring: frame store, slot bookkeeping, frame readout and
// the two-stage output path. Uses dfrr_pkg.
`default_nettype none

module dfrr_back
  import dfrr_pkg::*;
#(
  parameter int unsigned SLOTS       = 6,
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      frame_byte_o,
  output logic                   byte_valid_o,
  output logic                   last_o,
  output logic                   overflow_seen_o,
  output back_status_t           status_o
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned IW    = $clog2(FRAME_BYTES);
  localparam int unsigned AW    = SW + IW;
  localparam int unsigned DEPTH = SLOTS << IW;

  typedef enum logic [1:0] {
    ST_CMD  = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [SW-1:0]     ws_q, ws_d, rs_q, rs_d;
  logic [SW-1:0]     ws_nxt, rs_nxt;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              ovf_q, ovf_d;
  logic              rd_ovf_q, rd_ovf_d;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata;

  logic [IW-1:0]     slot_last_q [SLOTS];
  logic              slot_we;
  logic [IW-1:0]     cur_last;

  // Stage one travels alongside the memory read register; stage two is the output.
  logic              s1_v_q, s1_v_d;
  logic              s1_bv_q, s1_bv_d;
  logic              s1_last_q, s1_last_d;
  logic              s1_ovf_q, s1_ovf_d;
  logic              s1_load, s1_move, out_free, issue_ok;

  logic              out_v_q, out_v_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_bv_q, out_last_q, out_ovf_q;

  assign ws_nxt   = (ws_q == SW'(SLOTS - 1)) ? '0 : ws_q + 1'b1;
  assign rs_nxt   = (rs_q == SW'(SLOTS - 1)) ? '0 : rs_q + 1'b1;
  assign cur_last = slot_last_q[rs_q];

  assign out_free = !out_v_q || !out_stall_i;
  assign s1_move  = s1_v_q && out_free;
  assign issue_ok = !s1_v_q || out_free;

  assign cmd_pop_o = cmd_valid_i && (state_q == ST_CMD) &&
                     ((cmd_i.kind != CMD_READ) || issue_ok);

  always_comb begin
    state_d   = state_q;
    ws_d      = ws_q;
    rs_d      = rs_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    rd_ovf_d  = rd_ovf_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {ws_q, cnt_q};
    mem_raddr = {rs_q, idx_q};
    mem_wdata = cmd_i.data;
    slot_we   = 1'b0;
    s1_load   = 1'b0;
    s1_bv_d   = s1_bv_q;
    s1_last_d = s1_last_q;
    s1_ovf_d  = s1_ovf_q;
    case (state_q)
      ST_CMD: begin
        if (cmd_pop_o) begin
          case (cmd_i.kind)
            CMD_ERR: begin
              cnt_d = '0;
            end
            CMD_DATA: begin
              // Bytes past the slot's capacity are dropped.
              if (cnt_q < IW'(FRAME_BYTES - 1)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            CMD_CLOSE: begin
              if (ws_nxt == rs_q) begin
                ovf_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                slot_we   = 1'b1;
                ws_d      = ws_nxt;
              end
              cnt_d = '0;
            end
            CMD_READ: begin
              rd_ovf_d = ovf_q;
              ovf_d    = 1'b0;
              if (rs_q == ws_q) begin
                s1_load   = 1'b1;
                s1_bv_d   = 1'b0;
                s1_last_d = 1'b1;
                s1_ovf_d  = ovf_q;
              end else begin
                state_d = ST_READ;
                idx_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (issue_ok) begin
          mem_re    = 1'b1;
          s1_load   = 1'b1;
          s1_bv_d   = 1'b1;
          s1_last_d = (idx_q == cur_last);
          s1_ovf_d  = rd_ovf_q;
          idx_d     = idx_q + 1'b1;
          if (idx_q == cur_last) begin
            rs_d    = rs_nxt;
            state_d = ST_CMD;
          end
        end
      end
      default: begin
        state_d = ST_CMD;
      end
    endcase
  end

  assign s1_v_d  = s1_load || (s1_v_q && !s1_move);
  assign out_v_d = s1_move || (out_v_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CMD;
      ws_q     <= '0;
      rs_q     <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      rd_ovf_q <= 1'b0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ws_q     <= ws_d;
      rs_q     <= rs_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      rd_ovf_q <= rd_ovf_d;
      s1_v_q   <= s1_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_last_q[ws_q] <= cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_bv_q   <= s1_bv_d;
      s1_last_q <= s1_last_d;
      s1_ovf_q  <= s1_ovf_d;
    end
    if (s1_move) begin
      out_byte_q <= s1_bv_q ? mem_rd_q : '0;
      out_bv_q   <= s1_bv_q;
      out_last_q <= s1_last_q;
      out_ovf_q  <= s1_ovf_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign frame_byte_o    = out_byte_q;
  assign byte_valid_o    = out_bv_q;
  assign last_o          = out_last_q;
  assign overflow_seen_o = out_ovf_q;

  assign status_o.reading = (state_q == ST_READ);
  assign status_o.wr_slot = SLOT_MAX_W'(ws_q);
  assign status_o.rd_slot = SLOT_MAX_W'(rs_q);

endmodule

`default_nettype wire
